// ===== design/pve_pkg.sv =====
// pve_pkg: shared types and constants of the biased prefix varint encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pve_pkg;

   localparam int VALUE_W = 32;
   localparam int BYTE_W  = 8;
   localparam int MAX_BYTES = 5;
   localparam int WORD_W  = BYTE_W * MAX_BYTES;
   localparam int CNT_W   = $clog2(MAX_BYTES + 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // special codes
   localparam logic [VALUE_W-1:0] NAN_PATTERN = 32'h8000_0000;
   localparam logic [BYTE_W-1:0]  NAN_CODE    = 8'h20;
   localparam logic [BYTE_W-1:0]  ESC_NEG     = 8'hdf;
   localparam logic [BYTE_W-1:0]  ESC_POS     = 8'he0;

   // magnitude class limits
   localparam logic [VALUE_W-1:0] LIM1 = 32'h0000_0020;
   localparam logic [VALUE_W-1:0] LIM2 = 32'h0000_2020;
   localparam logic [VALUE_W-1:0] LIM3 = 32'h0020_2020;
   localparam logic [VALUE_W-1:0] LIM4 = 32'h1f20_2020;

   // per class offsets, modulo 2^32
   localparam logic [VALUE_W-1:0] OFF_POS1 = 32'h0000_0000;
   localparam logic [VALUE_W-1:0] OFF_NEG1 = 32'h0000_0000 - 32'h0000_00c0;
   localparam logic [VALUE_W-1:0] OFF_POS2 = 32'h0000_4000 - 32'h0000_0020;
   localparam logic [VALUE_W-1:0] OFF_NEG2 = 32'h0000_7fff + 32'h0000_0020;
   localparam logic [VALUE_W-1:0] OFF_POS3 = 32'h0080_0000 - 32'h0000_2020;
   localparam logic [VALUE_W-1:0] OFF_NEG3 = 32'h00bf_ffff + 32'h0000_2020;
   localparam logic [VALUE_W-1:0] OFF_POS4 = 32'hc000_0000 - 32'h0020_2020;
   localparam logic [VALUE_W-1:0] OFF_NEG4 = 32'hffff_ffff + 32'h0020_2020;

   // one classified value: code left aligned, first byte in the top lane
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [CNT_W-1:0]  count;
   } pve_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } pve_qstat_type;

endpackage
`default_nettype wire

// ===== design/pve_front.sv =====
// pve_front: classifies one value and builds its left aligned code word
// depends on pve_pkg
`timescale 1ns / 1ps
`default_nettype none
module pve_front (
   input  wire logic                          start,
   input  wire logic signed [pve_pkg::VALUE_W-1:0] req_value,
   input  wire pve_pkg::pve_qstat_type        qstat,
   output logic                               push,
   output pve_pkg::pve_entry_type             entry
);
   import pve_pkg::*;

   logic [VALUE_W-1:0] v;
   logic [VALUE_W-1:0] mag;
   logic [VALUE_W-1:0] offset;
   logic [VALUE_W-1:0] code;
   logic               neg;
   logic               is_nan;
   logic [CNT_W-1:0]   count;

   assign push = start && !qstat.full;

   always_comb begin
      v      = VALUE_W'(req_value);
      neg    = v[VALUE_W-1];
      mag    = neg ? (VALUE_W'(0) - v) : v;
      is_nan = (v == NAN_PATTERN);
      if (mag < LIM1) begin
         count  = CNT_W'(1);
         offset = neg ? OFF_NEG1 : OFF_POS1;
      end else if (mag < LIM2) begin
         count  = CNT_W'(2);
         offset = neg ? OFF_NEG2 : OFF_POS2;
      end else if (mag < LIM3) begin
         count  = CNT_W'(3);
         offset = neg ? OFF_NEG3 : OFF_POS3;
      end else if (mag < LIM4) begin
         count  = CNT_W'(4);
         offset = neg ? OFF_NEG4 : OFF_POS4;
      end else begin
         count  = CNT_W'(MAX_BYTES);
         offset = '0;
      end
      code = v + offset;

      entry.count = count;
      case (count)
         CNT_W'(1): entry.word = {code[BYTE_W-1:0], (WORD_W-BYTE_W)'(0)};
         CNT_W'(2): entry.word = {code[2*BYTE_W-1:0], (WORD_W-2*BYTE_W)'(0)};
         CNT_W'(3): entry.word = {code[3*BYTE_W-1:0], (WORD_W-3*BYTE_W)'(0)};
         CNT_W'(4): entry.word = {code, (WORD_W-VALUE_W)'(0)};
         default:   entry.word = {(neg ? ESC_NEG : ESC_POS), v};
      endcase

      // nan marker overrides the class choice
      if (is_nan) begin
         entry.count = CNT_W'(1);
         entry.word  = {NAN_CODE, (WORD_W-BYTE_W)'(0)};
      end
   end

endmodule
`default_nettype wire

// ===== design/pve_queue.sv =====
// pve_queue: short fifo of classified words between front and back
// depends on pve_pkg
`timescale 1ns / 1ps
`default_nettype none
module pve_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire pve_pkg::pve_entry_type push_entry,
   input  wire logic                   pop,
   output pve_pkg::pve_entry_type      pop_entry,
   output pve_pkg::pve_qstat_type      qstat
);
   import pve_pkg::*;

   pve_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign qstat.empty = (cnt_ff == '0);
   assign qstat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("push into full queue");
`endif

endmodule
`default_nettype wire

// ===== design/pve_back.sv =====
// pve_back: serializes queued code words, one byte per cycle, registered outputs
// depends on pve_pkg
`timescale 1ns / 1ps
`default_nettype none
module pve_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pve_pkg::pve_qstat_type      qstat,
   input  wire pve_pkg::pve_entry_type      pop_entry,
   output logic                             pop,
   output logic                             rsp_strobe,
   output logic [pve_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_last
);
   import pve_pkg::*;

   logic [WORD_W-1:0] sh_ff, sh_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              strobe_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;

   // reload as the final byte of the current word goes out, or while idle
   assign pop = (cnt_ff <= CNT_W'(1)) && !qstat.empty;

   always_comb begin
      if (pop) begin
         sh_in  = pop_entry.word;
         cnt_in = pop_entry.count;
      end else if (cnt_ff != '0) begin
         sh_in  = sh_ff << BYTE_W;
         cnt_in = cnt_ff - CNT_W'(1);
      end else begin
         sh_in  = sh_ff;
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         strobe_ff <= (cnt_ff != '0);
         last_ff   <= (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      byte_ff <= sh_ff[WORD_W-1 -: BYTE_W];
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

`ifndef ASSERT_OFF
   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last flag without strobe");
   a_word_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside one encoded value");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BYTES))
      else $error("byte count beyond five");
`endif

endmodule
`default_nettype wire

// ===== design/prefix_varint_int_encoder.sv =====
// prefix_varint_int_encoder: top level of the biased prefix varint encoder
// depends on pve_pkg, pve_front, pve_queue, pve_back
//
//   channel   ports                                      direction
//   request   start, busy, req_value[31:0] (signed)      in, taken when start && !busy
//   response  rsp_strobe, rsp_out_byte[7:0], rsp_last    out, one byte per strobe cycle
//
// each value becomes 1 to 5 bytes (5 in the escape form), streamed one byte
// per cycle; the byte serializer in the back end sets the rate
// with the back end idle an accepted value goes through the queue slot,
// the serializer load from the queue, then the output register
// a two entry queue lets the front keep taking values while bytes stream out;
// busy is high only while that queue is full
// synchronous active high reset empties the queue and the serializer
// the receiver cannot stall: every strobe cycle delivers one byte
`timescale 1ns / 1ps
`default_nettype none
module prefix_varint_int_encoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [pve_pkg::VALUE_W-1:0] req_value,
   output logic                                    rsp_strobe,
   output logic [pve_pkg::BYTE_W-1:0]              rsp_out_byte,
   output logic                                    rsp_last
);
   import pve_pkg::*;

   pve_qstat_type qstat;
   pve_entry_type push_entry;
   pve_entry_type pop_entry;
   logic          push;
   logic          pop;

   // front: class choice, offset add, left alignment of the code word
   pve_front u_front (
      .start     (start),
      .req_value (req_value),
      .qstat     (qstat),
      .push      (push),
      .entry     (push_entry)
   );

   // decoupling queue
   pve_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   // back: byte serializer with registered byte outputs
   pve_back u_back (
      .clock        (clock),
      .reset        (reset),
      .qstat        (qstat),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   assign busy = qstat.full;

endmodule
`default_nettype wire
